// ===== hw/rtl/llsf_pkg.sv =====
// ---------------------------------------------------------------------------
// llsf_pkg: shared types and constants of the line fit core
// Status codes, reset value of the interval register and the command
// bundle that drives the serial arithmetic unit.
// ---------------------------------------------------------------------------
package llsf_pkg;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_TOO_FEW  = 2'd1;
   localparam status_type STATUS_OVERFLOW = 2'd2;

   localparam logic [7:0] RESET_INTERVAL = 8'd30;

   // command to the serial unit: start pulses for one cycle
   typedef struct packed {
      logic start;
      logic divide;
   } llsf_cmd_type;

endpackage

// ===== hw/rtl/linear_least_squares_fit_core.sv =====
// ---------------------------------------------------------------------------
// linear_least_squares_fit_core: per-channel straight line fit
// Accumulates readings per channel and fits y = c0 + c1*x on the last one.
// ---------------------------------------------------------------------------
// Usage:
//   Input: an item is taken when start is high and busy is low. It carries
//   a channel, a signed Q8.8 reading and a last flag. Items for a channel
//   at or above NUM_CHANNELS are taken and dropped.
//   Accumulate: an ordinary reading keeps busy high through READ (read
//   and multiply index by value) and UPDATE (write back), no new item meanwhile.
//   Solve: a last reading runs the fit on a bit-serial multiply/divide unit,
//   one bit per cycle: five multiplies of MW = max(CW+1, 8) bits and two
//   divides of WIDE = 3*CW+32 bits, CW being the count width. The result
//   appears as busy drops.
//   A last reading with fewer than two readings answers without a fit.
//   Output: a result sits on the rsp_ ports for one cycle with rsp_valid;
//   the receiver cannot stall it. The channel is cleared before the fit.
//   Config: csr_data is written at csr_valid with csr_ready (always high).
//   Reset: all channels cleared, interval back to 30, no result pending.
// ---------------------------------------------------------------------------
module linear_least_squares_fit_core #(
   parameter int NUM_CHANNELS = 4,
   parameter int MAX_SAMPLES  = 65535
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_channel,
   input  logic signed [15:0]     req_sample,
   input  logic                   req_last,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_out_channel,
   output logic signed [31:0]     rsp_intercept,
   output logic signed [31:0]     rsp_slope,
   output logic [15:0]            rsp_sample_count,
   output llsf_pkg::status_type   rsp_status,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [7:0]             csr_data
);
   import llsf_pkg::*;

   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int NCH  = (NUM_CHANNELS < 4) ? NUM_CHANNELS : 4;
   localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int SYW  = CW + 16;
   localparam int SKYW = 2 * CW + 16;
   localparam int PW   = CW + 17;
   localparam int WIDE = 3 * CW + 32;
   localparam int MW   = (CW + 1 > 8) ? CW + 1 : 8;

   typedef enum logic [4:0] {
      IDLE, READ, UPDATE, CHECK,
      MUL_A, WAIT_A, MUL_DA, WAIT_DA, PREP_I, DIV_I, WAIT_I,
      MUL_B, WAIT_B, MUL_DB1, WAIT_DB1, MUL_DB2, WAIT_DB2,
      PREP_S, DIV_S, WAIT_S
   } state_type;

   state_type              state_ff;
   logic [7:0]             interval_ff;

   // per-channel accumulators
   logic [CW-1:0]          count_ff [NCH];
   logic signed [SYW-1:0]  sy_arr_ff [NCH];
   logic signed [SKYW-1:0] sky_arr_ff [NCH];
   logic                   ovf_arr_ff [NCH];

   // working registers
   logic [CHW-1:0]         ch_ff;
   logic signed [15:0]     y_ff;
   logic                   last_ff;
   logic                   full_ff;
   logic [CW-1:0]          n_ff;
   logic signed [SYW-1:0]  sy_ff;
   logic signed [SKYW-1:0] sky_ff;
   logic                   ovf_ff;
   logic signed [PW-1:0]   prod_ff;
   logic signed [WIDE-1:0] t_ff;
   logic signed [WIDE-1:0] u_ff;
   logic signed [WIDE-1:0] na_ff;
   logic signed [WIDE-1:0] nb_ff;
   logic [WIDE-1:0]        da_ff;
   logic [WIDE-1:0]        db_ff;
   logic [WIDE-1:0]        mag_ff;
   logic                   neg_ff;
   logic [31:0]            ia_ff;

   // result registers
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_ch_ff;
   logic [31:0]            rsp_ia_ff;
   logic [31:0]            rsp_sl_ff;
   logic [15:0]            rsp_cnt_ff;
   status_type             rsp_st_ff;

   // serial unit hookup
   llsf_cmd_type           cmd;
   logic [WIDE-1:0]        op_a;
   logic [WIDE-1:0]        op_b;
   logic                   su_done;
   logic [WIDE-1:0]        su_result;

   logic [CW-1:0]          cnt_rd;
   logic signed [WIDE-1:0] sy_w;
   logic signed [WIDE-1:0] sky_w;
   logic [WIDE-1:0]        n_w;
   logic [7:0]             t_sel;
   logic [31:0]            n32;
   logic                   accept;

   function automatic logic [31:0] round_sat(input logic [WIDE-1:0] q, input logic neg);
      logic [31:0] v;
      v = q[31:0];
      if (q[WIDE-1:31] == '0) begin
         return neg ? 32'd0 - v : v;
      end
      return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   always_comb begin
      cnt_rd = count_ff[ch_ff];
      sy_w   = WIDE'(sy_ff);
      sky_w  = WIDE'(sky_ff);
      n_w    = WIDE'(n_ff);
      t_sel  = (interval_ff == 8'd0) ? 8'd1 : interval_ff;
      n32    = 32'(n_ff);
      accept = start && (state_ff == IDLE);
   end

   // drive the serial unit from the solve steps
   always_comb begin
      cmd.start  = 1'b0;
      cmd.divide = 1'b0;
      op_a       = '0;
      op_b       = '0;
      case (state_ff)
         MUL_A: begin
            cmd.start = 1'b1;
            op_a      = sy_w <<< 9;
            op_b      = (n_w << 1) - WIDE'(1);
         end
         MUL_DA: begin
            cmd.start = 1'b1;
            op_a      = n_w;
            op_b      = n_w + WIDE'(1);
         end
         DIV_I: begin
            cmd.start  = 1'b1;
            cmd.divide = 1'b1;
            op_a       = (mag_ff << 1) + da_ff;
            op_b       = da_ff << 1;
         end
         MUL_B: begin
            cmd.start = 1'b1;
            op_a      = u_ff;
            op_b      = n_w - WIDE'(1);
         end
         MUL_DB1: begin
            cmd.start = 1'b1;
            op_a      = da_ff;
            op_b      = n_w - WIDE'(1);
         end
         MUL_DB2: begin
            cmd.start = 1'b1;
            op_a      = db_ff;
            op_b      = WIDE'(t_sel);
         end
         DIV_S: begin
            cmd.start  = 1'b1;
            cmd.divide = 1'b1;
            op_a       = (mag_ff << 1) + db_ff;
            op_b       = db_ff << 1;
         end
         default: begin
            cmd.start = 1'b0;
         end
      endcase
   end

   llsf_serial_unit #(
      .WIDE (WIDE),
      .MW   (MW)
   ) u_serial (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .op_a   (op_a),
      .op_b   (op_b),
      .done   (su_done),
      .result (su_result)
   );

   // sequencer: accumulate, then solve on the last item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         interval_ff  <= RESET_INTERVAL;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NCH; i++) begin
            count_ff[i]   <= '0;
            sy_arr_ff[i]  <= '0;
            sky_arr_ff[i] <= '0;
            ovf_arr_ff[i] <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            interval_ff <= csr_data;
         end
         case (state_ff)
            IDLE: begin
               if (accept && (32'(req_channel) < NUM_CHANNELS)) begin
                  ch_ff    <= req_channel[CHW-1:0];
                  y_ff     <= req_sample;
                  last_ff  <= req_last;
                  state_ff <= READ;
               end
            end
            READ: begin
               n_ff     <= cnt_rd;
               sy_ff    <= sy_arr_ff[ch_ff];
               sky_ff   <= sky_arr_ff[ch_ff];
               ovf_ff   <= ovf_arr_ff[ch_ff];
               full_ff  <= cnt_rd == CW'(MAX_SAMPLES);
               prod_ff  <= PW'($signed({1'b0, cnt_rd}) * y_ff);
               state_ff <= UPDATE;
            end
            UPDATE: begin
               if (full_ff) begin
                  ovf_ff <= 1'b1;
               end else begin
                  sy_ff  <= sy_ff + SYW'(y_ff);
                  sky_ff <= sky_ff + SKYW'(prod_ff);
                  n_ff   <= n_ff + CW'(1);
               end
               if (last_ff) begin
                  count_ff[ch_ff]   <= '0;
                  sy_arr_ff[ch_ff]  <= '0;
                  sky_arr_ff[ch_ff] <= '0;
                  ovf_arr_ff[ch_ff] <= 1'b0;
                  state_ff          <= CHECK;
               end else begin
                  ovf_arr_ff[ch_ff] <= ovf_ff | full_ff;
                  if (!full_ff) begin
                     count_ff[ch_ff]   <= n_ff + CW'(1);
                     sy_arr_ff[ch_ff]  <= sy_ff + SYW'(y_ff);
                     sky_arr_ff[ch_ff] <= sky_ff + SKYW'(prod_ff);
                  end
                  state_ff <= IDLE;
               end
            end
            CHECK: begin
               if (n_ff < CW'(2)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ch_ff    <= 2'(ch_ff);
                  rsp_ia_ff    <= '0;
                  rsp_sl_ff    <= '0;
                  rsp_cnt_ff   <= 16'(n_ff);
                  rsp_st_ff    <= STATUS_TOO_FEW;
                  state_ff     <= IDLE;
               end else begin
                  // 1536 times each sum; the weighted sum term feeds both numerators
                  t_ff     <= (sky_w <<< 10) + (sky_w <<< 9);
                  u_ff     <= (sy_w <<< 10) + (sy_w <<< 9);
                  state_ff <= MUL_A;
               end
            end
            MUL_A:   state_ff <= WAIT_A;
            WAIT_A: begin
               if (su_done) begin
                  na_ff    <= $signed(su_result) - t_ff;
                  state_ff <= MUL_DA;
               end
            end
            MUL_DA:  state_ff <= WAIT_DA;
            WAIT_DA: begin
               if (su_done) begin
                  da_ff    <= su_result;
                  state_ff <= PREP_I;
               end
            end
            PREP_I: begin
               neg_ff   <= na_ff[WIDE-1];
               mag_ff   <= na_ff[WIDE-1] ? -na_ff : na_ff;
               state_ff <= DIV_I;
            end
            DIV_I:   state_ff <= WAIT_I;
            WAIT_I: begin
               if (su_done) begin
                  ia_ff    <= round_sat(su_result, neg_ff);
                  state_ff <= MUL_B;
               end
            end
            MUL_B:   state_ff <= WAIT_B;
            WAIT_B: begin
               if (su_done) begin
                  nb_ff    <= (t_ff <<< 1) - $signed(su_result);
                  state_ff <= MUL_DB1;
               end
            end
            MUL_DB1: state_ff <= WAIT_DB1;
            WAIT_DB1: begin
               if (su_done) begin
                  db_ff    <= su_result;
                  state_ff <= MUL_DB2;
               end
            end
            MUL_DB2: state_ff <= WAIT_DB2;
            WAIT_DB2: begin
               if (su_done) begin
                  db_ff    <= su_result;
                  state_ff <= PREP_S;
               end
            end
            PREP_S: begin
               neg_ff   <= nb_ff[WIDE-1];
               mag_ff   <= nb_ff[WIDE-1] ? -nb_ff : nb_ff;
               state_ff <= DIV_S;
            end
            DIV_S:   state_ff <= WAIT_S;
            WAIT_S: begin
               if (su_done) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ch_ff    <= 2'(ch_ff);
                  rsp_ia_ff    <= ia_ff;
                  rsp_sl_ff    <= round_sat(su_result, neg_ff);
                  rsp_cnt_ff   <= (n32 > 32'd65535) ? 16'hFFFF : n32[15:0];
                  rsp_st_ff    <= ovf_ff ? STATUS_OVERFLOW : STATUS_OK;
                  state_ff     <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign busy             = state_ff != IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = rsp_ch_ff;
   assign rsp_intercept    = rsp_ia_ff;
   assign rsp_slope        = rsp_sl_ff;
   assign rsp_sample_count = rsp_cnt_ff;
   assign rsp_status       = rsp_st_ff;

   // a result strobe is never held: rsp_valid drops again after each strobe
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");

   // too few readings always gives a zero line
   a_too_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_TOO_FEW) |->
      (rsp_intercept == 32'sd0 && rsp_slope == 32'sd0))
      else $error("too-few result not zero");

   // a fitted result used at least two readings
   a_fit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_TOO_FEW) |-> rsp_sample_count >= 16'd2)
      else $error("fit with fewer than two readings");

   // a taken item on a real channel makes the core busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (32'(req_channel) < NUM_CHANNELS)) |=> busy)
      else $error("item taken but core idle");

   // the serial unit only answers during a solve
   a_done_in_solve: assert property (@(posedge clock) disable iff (reset)
      su_done |-> busy) else $error("serial unit done while idle");

endmodule

// ===== hw/rtl/llsf_serial_unit.sv =====
// ---------------------------------------------------------------------------
// llsf_serial_unit: bit-serial multiply and divide
// Multiply: op_a (two's complement) times op_b (unsigned, low MW bits),
// one multiplier bit per cycle. Divide: unsigned restoring division of
// op_a by op_b, one quotient bit per cycle. done pulses with the result.
// ---------------------------------------------------------------------------
module llsf_serial_unit #(
   parameter int WIDE = 80,
   parameter int MW   = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  llsf_pkg::llsf_cmd_type cmd,
   input  logic [WIDE-1:0]       op_a,
   input  logic [WIDE-1:0]       op_b,
   output logic                  done,
   output logic [WIDE-1:0]       result
);
   import llsf_pkg::*;

   localparam int CNTW = $clog2(WIDE + 1);

   logic            run_ff;
   logic            div_ff;
   logic            done_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [WIDE-1:0] acc_ff;
   logic [WIDE-1:0] sh_ff;
   logic [WIDE-1:0] den_ff;
   logic [WIDE:0]   rem_ff;

   logic [WIDE:0]   rem_sh;
   logic            fits;
   logic [WIDE:0]   rem_in;

   // one restoring step: bring in next dividend bit, try the subtract
   always_comb begin
      rem_sh = {rem_ff[WIDE-1:0], sh_ff[WIDE-1]};
      fits   = rem_sh >= {1'b0, den_ff};
      rem_in = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
   end

   // advance one bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         div_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            run_ff <= 1'b1;
            div_ff <= cmd.divide;
            cnt_ff <= cmd.divide ? CNTW'(WIDE) : CNTW'(MW);
            acc_ff <= '0;
            rem_ff <= '0;
            sh_ff  <= op_a;
            den_ff <= op_b;
         end else if (run_ff) begin
            if (div_ff) begin
               rem_ff <= rem_in;
               sh_ff  <= {sh_ff[WIDE-2:0], fits};
            end else begin
               if (den_ff[0]) begin
                  acc_ff <= acc_ff + sh_ff;
               end
               sh_ff  <= {sh_ff[WIDE-2:0], 1'b0};
               den_ff <= {1'b0, den_ff[WIDE-1:1]};
            end
            cnt_ff <= cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = div_ff ? sh_ff : acc_ff;

endmodule
